/* design/nsrf_pkg.sv */
// ----------------------------------------------------------------------------
// Not-shared region filter package
// Sizes, table row layout, beat types and controller states.
// ----------------------------------------------------------------------------
package nsrf_pkg;

  localparam int unsigned NODES        = 8;
  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned REGION_SHIFT = 15;

  localparam int unsigned NODE_W = $clog2(NODES);
  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned REG_W  = 32 - REGION_SHIFT;
  localparam int unsigned CNT_W  = $clog2(NODES * ENTRIES + 1);
  localparam int unsigned RCNT_W = $clog2(NODES + 1);
  localparam int unsigned ROW_W  = NODES * (REG_W + 1);
  localparam int unsigned MASK_N = (NODES < 8) ? NODES : 8;

  typedef enum logic [1:0] {
    OUT_RECORDED = 2'd0,
    OUT_FREE     = 2'd1,
    OUT_REPLACED = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_FIX_RD,
    ST_FIX_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [REG_W-1:0] region;
  } slot_t;

  typedef slot_t [NODES-1:0] row_t;

  typedef struct packed {
    logic [2:0]  node;
    logic [31:0] address;
    logic [5:0]  victim_index;
  } req_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [5:0]  entry_index;
    logic [16:0] region;
    logic        owner_kept;
    logic [7:0]  sharer_mask;
    logic [8:0]  cleared_count;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    row_t             wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef logic [63:0][IDX_W-1:0] vic_tbl_t;

  function automatic vic_tbl_t build_vic_tbl();
    vic_tbl_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = IDX_W'(i % ENTRIES);
    end
    return t;
  endfunction

  // Victim index wrapped into the table depth.
  localparam vic_tbl_t VIC_TBL = build_vic_tbl();

endpackage

/* design/nsrf_if.sv */
// ----------------------------------------------------------------------------
// Not-shared region filter channels
// Valid/ready channels for access beats and result beats.
// ----------------------------------------------------------------------------
interface nsrf_req_if import nsrf_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  node;
  logic [31:0] address;
  logic [5:0]  victim_index;

  modport source (output valid, output node, output address, output victim_index,
                  input ready);
  modport sink (input valid, input node, input address, input victim_index,
                output ready);
endinterface

interface nsrf_res_if import nsrf_pkg::*; ();
  logic        valid;
  logic        ready;
  outcome_e    outcome;
  logic [5:0]  entry_index;
  logic [16:0] region;
  logic        owner_kept;
  logic [7:0]  sharer_mask;
  logic [8:0]  cleared_count;

  modport source (output valid, output outcome, output entry_index, output region,
                  output owner_kept, output sharer_mask, output cleared_count,
                  input ready);
  modport sink (input valid, input outcome, input entry_index, input region,
                input owner_kept, input sharer_mask, input cleared_count,
                output ready);
endinterface

/* design/nsrf_ram.sv */
// ----------------------------------------------------------------------------
// Not-shared region filter table RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nsrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/nsrf_ctrl.sv */
// ----------------------------------------------------------------------------
// Not-shared region filter controller
// Scans the requesting node's entries; if the region is not found there, sweeps
// all rows to clear other nodes' copies of it, then writes the own entry back.
// ----------------------------------------------------------------------------
module nsrf_ctrl import nsrf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  req_t     req_i,
  output logic     req_ready_o,
  output ram_req_t ram_o,
  input  row_t     ram_rdata_i,
  output logic     res_valid_o,
  output result_t  res_o,
  input  logic     res_ready_i
);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [REG_W-1:0]  reg_q, reg_d;
  logic [16:0]       region_q, region_d;
  logic [IDX_W-1:0]  vic_q, vic_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  outcome_e          outcome_q, outcome_d;
  logic              kept_q, kept_d;
  logic [NODES-1:0]  mask_q, mask_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              accept;
  logic              node_ok;
  logic [31:0]       shifted;
  logic              last;
  logic [IDX_W-1:0]  ptr_nxt;
  slot_t             own;
  logic              own_hit;
  row_t              swept_row;
  logic [RCNT_W-1:0] row_cnt;
  logic [NODES-1:0]  row_mask;
  row_t              fix_row;
  logic [7:0]        mask8;

  assign accept  = req_valid_i && req_ready_o;
  assign node_ok = (32'(req_i.node) < NODES);
  assign shifted = req_i.address >> REGION_SHIFT;
  assign last    = (ptr_q == IDX_W'(ENTRIES - 1));
  assign ptr_nxt = last ? '0 : ptr_q + IDX_W'(1);
  assign own     = ram_rdata_i[node_q];
  assign own_hit = own.valid && (own.region == reg_q);

  always_comb begin
    swept_row = ram_rdata_i;
    row_cnt   = '0;
    row_mask  = '0;
    for (int n = 0; n < NODES; n++) begin
      if ((NODE_W'(n) != node_q) && ram_rdata_i[n].valid &&
          (ram_rdata_i[n].region == reg_q)) begin
        swept_row[n].valid = 1'b0;
        row_cnt            = row_cnt + RCNT_W'(1);
        row_mask[n]        = 1'b1;
      end
    end
  end

  always_comb begin
    fix_row                = ram_rdata_i;
    fix_row[node_q].valid  = (cnt_q == '0);
    fix_row[node_q].region = reg_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = node_ok ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (own_hit) begin
          state_d = ST_DONE;
        end else if (!own.valid || last) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (last) begin
          state_d = ST_FIX_RD;
        end
      end
      ST_FIX_RD: state_d = ST_FIX_WR;
      ST_FIX_WR: state_d = ST_DONE;
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    ram_o.we    = 1'b0;
    ram_o.waddr = ptr_q;
    ram_o.wdata = swept_row;
    ram_o.raddr = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_o.we    = 1'b1;
        ram_o.wdata = '0;
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
      end
      ST_SCAN: begin
        if (!own_hit && own.valid && !last) begin
          ram_o.raddr = ptr_nxt;
        end
      end
      ST_SWEEP: begin
        ram_o.we    = 1'b1;
        ram_o.raddr = ptr_nxt;
      end
      ST_FIX_RD: begin
        ram_o.raddr = idx_q;
      end
      ST_FIX_WR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = idx_q;
        ram_o.wdata = fix_row;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    ptr_d     = ptr_q;
    node_d    = node_q;
    reg_d     = reg_q;
    region_d  = region_q;
    vic_d     = vic_q;
    idx_d     = idx_q;
    outcome_d = outcome_q;
    kept_d    = kept_q;
    mask_d    = mask_q;
    cnt_d     = cnt_q;
    case (state_q)
      ST_CLEAR: begin
        ptr_d = ptr_nxt;
      end
      ST_IDLE: begin
        if (accept) begin
          ptr_d     = '0;
          node_d    = NODE_W'(req_i.node);
          reg_d     = shifted[REG_W-1:0];
          region_d  = shifted[16:0];
          vic_d     = VIC_TBL[req_i.victim_index];
          idx_d     = '0;
          outcome_d = OUT_RECORDED;
          kept_d    = 1'b0;
          mask_d    = '0;
          cnt_d     = '0;
        end
      end
      ST_SCAN: begin
        if (own_hit) begin
          outcome_d = OUT_RECORDED;
          idx_d     = ptr_q;
          kept_d    = 1'b1;
        end else if (!own.valid) begin
          outcome_d = OUT_FREE;
          idx_d     = ptr_q;
          ptr_d     = '0;
        end else if (last) begin
          outcome_d = OUT_REPLACED;
          idx_d     = vic_q;
          ptr_d     = '0;
        end else begin
          ptr_d = ptr_nxt;
        end
      end
      ST_SWEEP: begin
        ptr_d  = ptr_nxt;
        cnt_d  = cnt_q + CNT_W'(row_cnt);
        mask_d = mask_q | row_mask;
      end
      ST_FIX_WR: begin
        kept_d = (cnt_q == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    reg_q     <= reg_d;
    region_q  <= region_d;
    vic_q     <= vic_d;
    idx_q     <= idx_d;
    outcome_q <= outcome_d;
    kept_q    <= kept_d;
    mask_q    <= mask_d;
    cnt_q     <= cnt_d;
  end

  always_comb begin
    mask8               = '0;
    mask8[MASK_N-1:0]   = mask_q[MASK_N-1:0];
    res_o.outcome       = outcome_q;
    res_o.entry_index   = 6'(idx_q);
    res_o.region        = region_q;
    res_o.owner_kept    = kept_q;
    res_o.sharer_mask   = mask8;
    res_o.cleared_count = 9'(cnt_q);
  end

endmodule

/* design/not_shared_region_filter.sv */
// ----------------------------------------------------------------------------
// Not-shared region filter
// Per-node tables of regions that no other node holds, kept in one RAM.
// ----------------------------------------------------------------------------
// The tables live in one RAM of ENTRIES rows, each row holding that entry for
// every node. After reset the block clears every row of the RAM and accepts
// no beat until it is done. An access whose region is already recorded ends
// once the scan finds the matching entry. An access that writes an entry
// takes a scan of the node's entries up to a free one or the last row, a
// full pass over all rows to invalidate other nodes' copies of the region,
// and a final read and write of the own entry, all through the RAM's single
// read and write port. One access is processed at a time; a finished result
// is held in an output register, so the next access can start while the
// result waits.
module not_shared_region_filter import nsrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  nsrf_req_if.sink   in_i,
  nsrf_res_if.source out_o
);

  req_t     req;
  ram_req_t ram_req;
  row_t     ram_rdata;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  logic     out_valid_q, out_valid_d;
  result_t  out_q, out_d;

  assign req.node         = in_i.node;
  assign req.address      = in_i.address;
  assign req.victim_index = in_i.victim_index;

  nsrf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  nsrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_i       (req),
    .req_ready_o (in_i.ready),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.outcome       = out_q.outcome;
  assign out_o.entry_index   = out_q.entry_index;
  assign out_o.region        = out_q.region;
  assign out_o.owner_kept    = out_q.owner_kept;
  assign out_o.sharer_mask   = out_q.sharer_mask;
  assign out_o.cleared_count = out_q.cleared_count;

endmodule
